@@ rtl/sim_pkg.sv @@
package sim_pkg;

   // Vector and configuration formats.
   localparam int VEC_W      = 32;
   localparam int CFG_W      = 20;
   localparam int CFG_FRAC   = 12;
   localparam int FRAC       = 36;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3 * CFG_W;

   // Internal widths. K is a full bottom-block coefficient in Q.36.
   localparam int C_W     = 2 * CFG_W;
   localparam int K_W     = C_W + CFG_W + 2;
   localparam int KL_W    = 31;
   localparam int KH_W    = K_W - KL_W;
   localparam int ACC_W   = K_W + VEC_W + 4;
   localparam int RND_W   = ACC_W - FRAC;
   localparam int J_SHIFT = FRAC - CFG_FRAC;
   localparam int M_SHIFT = FRAC - CFG_FRAC;
   localparam int C_SHIFT = FRAC - 2 * CFG_FRAC;

   localparam logic [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
   localparam logic [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MASS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COM  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIAG = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFD = 2'd3;

   typedef logic [2:0][VEC_W-1:0] vec3_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] ang_x;
      logic signed [VEC_W-1:0] ang_y;
      logic signed [VEC_W-1:0] ang_z;
      logic signed [VEC_W-1:0] lin_x;
      logic signed [VEC_W-1:0] lin_y;
      logic signed [VEC_W-1:0] lin_z;
   } req_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] top_x;
      logic signed [VEC_W-1:0] top_y;
      logic signed [VEC_W-1:0] top_z;
      logic signed [VEC_W-1:0] bot_x;
      logic signed [VEC_W-1:0] bot_y;
      logic signed [VEC_W-1:0] bot_z;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0]      mass;
      logic [CSR_DATA_W-1:0] com;
      logic [CSR_DATA_W-1:0] diag;
      logic [CSR_DATA_W-1:0] offd;
   } cfg_type;

   typedef struct packed {
      logic                       valid;
      logic [CFG_W-1:0]           mass;
      vec3_type                   ang;
      vec3_type                   lin;
      logic [2:0][C_W-1:0]        c;
      logic [2:0][2:0][K_W-1:0]   k;
   } coef_type;

   typedef struct packed {
      logic                  valid;
      logic [5:0][ACC_W-1:0] acc;
   } acc_type;

   // Index of an off-diagonal entry of J in the packed register.
   function automatic int off_idx(input int i, input int j);
      return i + j - 1;
   endfunction

endpackage

@@ rtl/spatial_inertia_multiply.sv @@
// Spatial rigid-body inertia times a spatial motion vector, fixed point.
//
// Configuration: mass, center of mass and rotational inertia are written
// through the csr_ port (index, data, write enable), one register per write,
// and take effect at once. The user must see that they are written only
// while no request is in flight; the block itself does not enforce this.
// Requests: a motion vector (angular x/y/z, linear x/y/z, Q16.16) is taken
// at each rising edge where start is high and busy is low. busy is high
// only during reset, so a new request can enter on every cycle.
// Results: each request yields one spatial force vector on rsp_data,
// marked by rsp_valid for exactly one cycle. Throughput is one request per
// cycle; each request passes the six register stages in order:
// center-of-mass product, coefficient build, multipliers, two adder
// stages, and round/saturate.
// The receiver cannot stall; results are not held.
// Reset clears the configuration to zero and drops any request in flight.
module spatial_inertia_multiply
   import sim_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     accept;
   coef_type coef;
   acc_type  acc;

   assign busy   = reset;
   assign accept = start & ~busy;

   // Configuration registers: each write keeps the low bits it needs.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MASS: cfg_in.mass = csr_data[CFG_W-1:0];
            CSR_COM:  cfg_in.com  = csr_data;
            CSR_DIAG: cfg_in.diag = csr_data;
            CSR_OFFD: cfg_in.offd = csr_data;
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Two stages that build c = m*h and the bottom-block coefficients.
   sim_coef u_coef (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .coef   (coef)
   );

   // Products and the exact Q.52 sums.
   sim_mac u_mac (
      .clock (clock),
      .reset (reset),
      .coef  (coef),
      .acc   (acc)
   );

   // Rounding to Q.16, saturation and the result register.
   sim_round u_round (
      .clock     (clock),
      .reset     (reset),
      .acc       (acc),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

`ifndef SYNTHESIS
   // Every result comes from a request that has passed all six register stages.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 6))
      else $error("result without a matching request");

   // A saturated result must hold at least one clipped component.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.top_x == VEC_MAX || rsp_data.top_x == VEC_MIN ||
          rsp_data.top_y == VEC_MAX || rsp_data.top_y == VEC_MIN ||
          rsp_data.top_z == VEC_MAX || rsp_data.top_z == VEC_MIN ||
          rsp_data.bot_x == VEC_MAX || rsp_data.bot_x == VEC_MIN ||
          rsp_data.bot_y == VEC_MAX || rsp_data.bot_y == VEC_MIN ||
          rsp_data.bot_z == VEC_MAX || rsp_data.bot_z == VEC_MIN))
      else $error("saturation flag without a clipped component");
`endif

endmodule

@@ rtl/sim_coef.sv @@
module sim_coef
   import sim_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req,
   input  cfg_type  cfg,
   output coef_type coef
);

   logic signed [CFG_W-1:0] h  [3];
   logic signed [CFG_W-1:0] jd [3];
   logic signed [CFG_W-1:0] jo [3];

   logic                vld_a_ff;
   vec3_type            ang_a_ff;
   vec3_type            lin_a_ff;
   logic [2:0][C_W-1:0] c_a_ff;
   logic [2:0][C_W-1:0] c_a_in;

   logic [2:0][2:0][K_W-1:0] k_in;
   coef_type                 coef_ff;

   always_comb begin
      for (int n = 0; n < 3; n++) begin
         h[n]  = cfg.com[n*CFG_W +: CFG_W];
         jd[n] = cfg.diag[n*CFG_W +: CFG_W];
         jo[n] = cfg.offd[n*CFG_W +: CFG_W];
         c_a_in[n] = C_W'($signed({1'b0, cfg.mass}) * h[n]);
      end
   end

   // First stage: capture the vector and form c = m*h.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else begin
         vld_a_ff <= accept;
      end
      ang_a_ff <= {req.ang_z, req.ang_y, req.ang_x};
      lin_a_ff <= {req.lin_z, req.lin_y, req.lin_x};
      c_a_ff   <= c_a_in;
   end

   // Second stage: K = J - skew(h)*skew(c), all in Q.36.
   always_comb begin
      int p;
      int q;
      for (int i = 0; i < 3; i++) begin
         p = (i == 2) ? 0 : i + 1;
         q = (i == 0) ? 2 : i - 1;
         for (int j = 0; j < 3; j++) begin
            if (i == j) begin
               k_in[i][j] = (K_W'(jd[i]) <<< J_SHIFT)
                          + K_W'($signed(c_a_ff[p]) * h[p])
                          + K_W'($signed(c_a_ff[q]) * h[q]);
            end else begin
               k_in[i][j] = (K_W'(jo[off_idx(i, j)]) <<< J_SHIFT)
                          - K_W'($signed(c_a_ff[i]) * h[j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.valid <= 1'b0;
      end else begin
         coef_ff.valid <= vld_a_ff;
      end
      coef_ff.mass <= cfg.mass;
      coef_ff.ang  <= ang_a_ff;
      coef_ff.lin  <= lin_a_ff;
      coef_ff.c    <= c_a_ff;
      coef_ff.k    <= k_in;
   end

   assign coef = coef_ff;

endmodule

@@ rtl/sim_mac.sv @@
module sim_mac
   import sim_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  coef_type coef,
   output acc_type  acc
);

   localparam int PM_W = CFG_W + 1 + VEC_W;
   localparam int PC_W = C_W + VEC_W;
   localparam int PK_W = 2 * VEC_W;
   localparam logic signed [ACC_W-1:0] HALF =
      {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

   logic                       vld_p_ff;
   logic [2:0][PM_W-1:0]       pm_in, pm_ff;
   logic [2:0][PC_W-1:0]       pa1_in, pa1_ff, pa2_in, pa2_ff;
   logic [2:0][PC_W-1:0]       pl1_in, pl1_ff, pl2_in, pl2_ff;
   logic [2:0][2:0][PK_W-1:0]  kh_in, kh_ff, kl_in, kl_ff;

   logic                  vld_s_ff;
   logic [5:0][ACC_W-1:0] sa_in, sa_ff, sb_in, sb_ff;
   acc_type               acc_ff;

   // Product stage: every multiplier is at most about 40 by 32 bits.
   always_comb begin
      int p;
      int q;
      for (int i = 0; i < 3; i++) begin
         p = (i == 2) ? 0 : i + 1;
         q = (i == 0) ? 2 : i - 1;
         pm_in[i]  = PM_W'($signed({1'b0, coef.mass}) * $signed(coef.lin[i]));
         pa1_in[i] = PC_W'($signed(coef.c[q]) * $signed(coef.ang[p]));
         pa2_in[i] = PC_W'($signed(coef.c[p]) * $signed(coef.ang[q]));
         pl1_in[i] = PC_W'($signed(coef.c[p]) * $signed(coef.lin[q]));
         pl2_in[i] = PC_W'($signed(coef.c[q]) * $signed(coef.lin[p]));
         for (int j = 0; j < 3; j++) begin
            kh_in[i][j] = PK_W'($signed(coef.k[i][j][K_W-1:KL_W])
                                * $signed(coef.ang[j]));
            kl_in[i][j] = PK_W'($signed({1'b0, coef.k[i][j][KL_W-1:0]})
                                * $signed(coef.ang[j]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p_ff <= 1'b0;
      end else begin
         vld_p_ff <= coef.valid;
      end
      pm_ff  <= pm_in;
      pa1_ff <= pa1_in;
      pa2_ff <= pa2_in;
      pl1_ff <= pl1_in;
      pl2_ff <= pl2_in;
      kh_ff  <= kh_in;
      kl_ff  <= kl_in;
   end

   // Partial sums, aligned to Q.52, with the rounding half folded in.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sa_in[i] = (ACC_W'($signed(pm_ff[i])) <<< M_SHIFT) + HALF;
         sb_in[i] = (ACC_W'($signed(pa1_ff[i])) - ACC_W'($signed(pa2_ff[i])))
                    <<< C_SHIFT;
         sa_in[3+i] = (ACC_W'($signed(kh_ff[i][0])) + ACC_W'($signed(kh_ff[i][1]))
                      + ACC_W'($signed(kh_ff[i][2]))) <<< KL_W;
         sb_in[3+i] = ACC_W'($signed(kl_ff[i][0])) + ACC_W'($signed(kl_ff[i][1]))
                    + ACC_W'($signed(kl_ff[i][2]))
                    + ((ACC_W'($signed(pl1_ff[i])) - ACC_W'($signed(pl2_ff[i])))
                       <<< C_SHIFT)
                    + HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s_ff <= 1'b0;
      end else begin
         vld_s_ff <= vld_p_ff;
      end
      sa_ff <= sa_in;
      sb_ff <= sb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff.valid <= 1'b0;
      end else begin
         acc_ff.valid <= vld_s_ff;
      end
      for (int n = 0; n < 6; n++) begin
         acc_ff.acc[n] <= sa_ff[n] + sb_ff[n];
      end
   end

   assign acc = acc_ff;

endmodule

@@ rtl/sim_round.sv @@
module sim_round
   import sim_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  acc_type acc,
   output logic    rsp_valid,
   output rsp_type rsp
);

   logic [RND_W-1:0]      r   [6];
   logic [5:0]            fit;
   logic [5:0][VEC_W-1:0] val;
   logic                  valid_ff;
   rsp_type               rsp_ff;

   // The sum already carries the rounding half; dropping the fraction
   // bits rounds, and the value fits when the bits above the sign agree.
   always_comb begin
      for (int n = 0; n < 6; n++) begin
         r[n]   = acc.acc[n][ACC_W-1:FRAC];
         fit[n] = (&r[n][RND_W-1:VEC_W-1]) | ~(|r[n][RND_W-1:VEC_W-1]);
         if (fit[n]) begin
            val[n] = r[n][VEC_W-1:0];
         end else if (r[n][RND_W-1]) begin
            val[n] = VEC_MIN;
         end else begin
            val[n] = VEC_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= acc.valid;
      end
      rsp_ff.top_x     <= val[0];
      rsp_ff.top_y     <= val[1];
      rsp_ff.top_z     <= val[2];
      rsp_ff.bot_x     <= val[3];
      rsp_ff.bot_y     <= val[4];
      rsp_ff.bot_z     <= val[5];
      rsp_ff.saturated <= ~(&fit);
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ bench/spatial_inertia_multiply_checker.sv @@
module spatial_inertia_multiply_checker
   import sim_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_data,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_type;

   logic [CFG_W-1:0]      mass_q;
   logic [CSR_DATA_W-1:0] com_q;
   logic [CSR_DATA_W-1:0] diag_q;
   logic [CSR_DATA_W-1:0] offd_q;
   rsp_type               force_queue[$];

   function automatic wide_type field_of(input logic [CSR_DATA_W-1:0] packed_val, input int k);
      wide_type f;
      f = $signed(packed_val[CFG_W*k +: CFG_W]);
      return f;
   endfunction

   function automatic logic [VEC_W-1:0] round_clip(input wide_type sum, inout logic clipped);
      wide_type r;
      r = (sum + (wide_type'(1) <<< (FRAC - 1))) >>> FRAC;
      if (r > (wide_type'(1) <<< (VEC_W - 1)) - wide_type'(1)) begin
         clipped = 1'b1;
         return VEC_MAX;
      end
      if (r < -(wide_type'(1) <<< (VEC_W - 1))) begin
         clipped = 1'b1;
         return VEC_MIN;
      end
      return r[VEC_W-1:0];
   endfunction

   // Spatial force of the configured body for one motion vector.
   function automatic rsp_type spatial_force(input req_type v);
      wide_type a[3], l[3], h[3], c[3], cq[3], jm[3][3], acc[6];
      wide_type m, m36;
      logic     clipped;
      rsp_type  r;
      int       p, q;
      a[0] = v.ang_x; a[1] = v.ang_y; a[2] = v.ang_z;
      l[0] = v.lin_x; l[1] = v.lin_y; l[2] = v.lin_z;
      m = {108'b0, mass_q};
      m36 = m <<< 24;
      for (int i = 0; i < 3; i++) begin
         h[i] = field_of(com_q, i);
         c[i] = m * h[i];
         cq[i] = c[i] <<< 12;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (i == j) begin
               p = (i + 1) % 3;
               q = (i + 2) % 3;
               jm[i][j] = (field_of(diag_q, i) <<< 24) + c[p] * h[p] + c[q] * h[q];
            end else begin
               jm[i][j] = (field_of(offd_q, i + j - 1) <<< 24) - c[i] * h[j];
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         p = (i + 1) % 3;
         q = (i + 2) % 3;
         acc[i] = m36 * l[i] + cq[q] * a[p] - cq[p] * a[q];
         acc[3+i] = jm[i][0] * a[0] + jm[i][1] * a[1] + jm[i][2] * a[2]
                  + cq[p] * l[q] - cq[q] * l[p];
      end
      clipped = 1'b0;
      r.top_x = round_clip(acc[0], clipped);
      r.top_y = round_clip(acc[1], clipped);
      r.top_z = round_clip(acc[2], clipped);
      r.bot_x = round_clip(acc[3], clipped);
      r.bot_y = round_clip(acc[4], clipped);
      r.bot_z = round_clip(acc[5], clipped);
      r.saturated = clipped;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [VEC_W-1:0] want,
                              input logic [VEC_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mass_q <= '0;
         com_q  <= '0;
         diag_q <= '0;
         offd_q <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MASS: mass_q <= csr_data[CFG_W-1:0];
               CSR_COM:  com_q  <= csr_data;
               CSR_DIAG: diag_q <= csr_data;
               CSR_OFFD: offd_q <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (force_queue.size() == 0) begin
               $display("%0t: result with none expected, actual %h", $realtime, rsp_data);
               fail_count++;
            end else begin
               want = force_queue.pop_front();
               check_field("top_x", want.top_x, rsp_data.top_x);
               check_field("top_y", want.top_y, rsp_data.top_y);
               check_field("top_z", want.top_z, rsp_data.top_z);
               check_field("bot_x", want.bot_x, rsp_data.bot_x);
               check_field("bot_y", want.bot_y, rsp_data.bot_y);
               check_field("bot_z", want.bot_z, rsp_data.bot_z);
               check_field("saturated", VEC_W'(want.saturated), VEC_W'(rsp_data.saturated));
            end
         end
         if (start && !busy)
            force_queue.push_back(spatial_force(req_data));
         pending_count = force_queue.size();
      end
   end

endmodule

@@ bench/spatial_inertia_multiply_tb.sv @@
module spatial_inertia_multiply_tb;
   import sim_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Kinds of body that a phase loads into the configuration registers.
   typedef enum int {BODY_MAX, BODY_MIN, BODY_RANDOM, BODY_SMALL} body_kind_type;

   // Idle margin that drain waits after the last expected result is back.
   localparam int SETTLE_CYCLES = 12;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   int                    fail_count;
   int                    pending_count;
   bit                    allow_gaps;

   spatial_inertia_multiply dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   spatial_inertia_multiply_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block never answers or never drops busy.
   initial begin
      #2ms;
      $display("Simulation FAILED");
      $finish;
   end

   // One Q16.16 component: mostly full range, sometimes small or an extreme.
   function automatic logic [VEC_W-1:0] pick_component();
      case ($urandom_range(0, 9))
         0:       return VEC_MAX;
         1:       return VEC_MIN;
         2, 3, 4: return VEC_W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return VEC_W'($urandom);
      endcase
   endfunction

   function automatic req_type pick_vector();
      req_type v;
      v.ang_x = pick_component();
      v.ang_y = pick_component();
      v.ang_z = pick_component();
      v.lin_x = pick_component();
      v.lin_y = pick_component();
      v.lin_z = pick_component();
      return v;
   endfunction

   // One signed Q8.12 configuration field of the given kind.
   function automatic logic [CFG_W-1:0] pick_field(input body_kind_type kind);
      case (kind)
         BODY_MAX:   return {1'b0, {(CFG_W-1){1'b1}}};
         BODY_MIN:   return {1'b1, {(CFG_W-1){1'b0}}};
         BODY_SMALL: return CFG_W'($signed($urandom_range(0, 1 << 15)) - (1 << 14));
         default:    return CFG_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_triple(input body_kind_type kind);
      return {pick_field(kind), pick_field(kind), pick_field(kind)};
   endfunction

   // Present one request and hold it until the block takes it. Unless a gap
   // is drawn, start stays high on return so back-to-back requests need no extra cycle.
   task automatic send_request(input req_type v);
      req_data <= v;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (allow_gaps && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Let every expected result come back before touching the registers.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The write enable is left high; the caller drops it after the last write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
   endtask

   // Load a whole body. Mass is unsigned, so the maximum kind gives all ones
   // and the minimum kind zero mass.
   task automatic load_body(input body_kind_type kind);
      logic [CSR_DATA_W-1:0] mass_word;
      mass_word = CSR_DATA_W'({$urandom, $urandom});
      if (kind == BODY_MAX)
         mass_word[CFG_W-1:0] = '1;
      else if (kind == BODY_MIN)
         mass_word[CFG_W-1:0] = '0;
      else if (kind == BODY_SMALL)
         mass_word[CFG_W-1:0] = CFG_W'($urandom_range(0, 1 << 14));
      drain();
      write_csr(CSR_MASS, mass_word);
      write_csr(CSR_COM, pick_triple(kind));
      write_csr(CSR_DIAG, pick_triple(kind));
      write_csr(CSR_OFFD, pick_triple(kind));
      csr_we <= 1'b0;
   endtask

   // Short directed set: zero, extremes, unit vectors, and a pair of minus
   // and plus one LSB vectors whose tiny products exercise the rounding.
   task automatic directed_set();
      req_type v;
      v = '0;
      send_request(v);
      v = {6{VEC_MAX}};
      send_request(v);
      v = {6{VEC_MIN}};
      send_request(v);
      v = {VEC_MAX, VEC_MIN, VEC_MAX, VEC_MIN, VEC_MAX, VEC_MIN};
      send_request(v);
      for (int k = 0; k < 6; k++) begin
         v = '0;
         v[VEC_W*k +: VEC_W] = VEC_W'(32'sh0001_0000);
         send_request(v);
      end
      v = {6{VEC_W'(-1)}};
      send_request(v);
      v = {6{VEC_W'(1)}};
      send_request(v);
   endtask

   initial begin
      body_kind_type kind;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_MASS;
      csr_data = '0;
      allow_gaps = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The body after reset is all zero, so every result must be zero.
      directed_set();
      load_body(BODY_MAX);
      directed_set();
      load_body(BODY_MIN);
      directed_set();

      // Random phases, each with a fresh body; the last runs without gaps.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0:       kind = BODY_RANDOM;
            1:       kind = BODY_SMALL;
            2:       kind = BODY_MAX;
            default: kind = (phase == 3) ? BODY_MIN : BODY_SMALL;
         endcase
         load_body(kind);
         allow_gaps = (phase != 7);
         repeat (230) send_request(pick_vector());
      end

      drain();
      if (fail_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
